FILE: rtl/core/nkdpm_pkg.sv
// Shared types and codes for the nearest-k depth pixel mean block.
// No dependencies; imported by every module of the block.
`default_nettype none

package nkdpm_pkg;

  // Configuration register indexes.
  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_KEEP_COUNT  = 1'b1;

  localparam int unsigned CFG_DATA_W   = 12;
  localparam int unsigned DEPTH_PORT_W = 16;
  localparam int unsigned MCOL_PORT_W  = 11;
  localparam int unsigned KEPT_PORT_W  = 7;

  localparam int unsigned WIDTH_RESET = 640;
  localparam int unsigned KEEP_RESET  = 16;

  // Control of one table cell for the current cycle.
  typedef struct packed {
    logic ins;    // insert the new pixel into the sorted row
    logic drain;  // shift every entry one cell toward cell 0
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DRAIN = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/nkdpm_cell.sv
// One entry of the sorted table of kept pixels.
// Depends on nkdpm_pkg for the cell control struct.
`default_nettype none

module nkdpm_cell import nkdpm_pkg::*; #(
  parameter int unsigned DW = 16,
  parameter int unsigned CW = 11
) (
  input  wire logic          clk_i,
  input  wire cell_ctl_t     ctl_i,
  input  wire logic          valid_i,
  input  wire logic [DW-1:0] new_depth_i,
  input  wire logic [CW-1:0] new_col_i,
  input  wire logic          left_le_i,
  input  wire logic [DW-1:0] left_depth_i,
  input  wire logic [CW-1:0] left_col_i,
  input  wire logic [DW-1:0] right_depth_i,
  input  wire logic [CW-1:0] right_col_i,
  output logic               le_o,
  output logic               gt_o,
  output logic      [DW-1:0] depth_o,
  output logic      [CW-1:0] col_o
);

  logic [DW-1:0] depth_q, depth_d;
  logic [CW-1:0] col_q, col_d;

  // An entry that is not nearer-or-equal moves one place right to make room.
  assign le_o = valid_i && (depth_q <= new_depth_i);
  assign gt_o = valid_i && (depth_q > new_depth_i);

  always_comb begin
    depth_d = depth_q;
    col_d   = col_q;
    if (ctl_i.drain) begin
      depth_d = right_depth_i;
      col_d   = right_col_i;
    end else if (ctl_i.ins && !le_o) begin
      if (left_le_i) begin
        depth_d = new_depth_i;
        col_d   = new_col_i;
      end else begin
        depth_d = left_depth_i;
        col_d   = left_col_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    depth_q <= depth_d;
    col_q   <= col_d;
  end

  assign depth_o = depth_q;
  assign col_o   = col_q;

endmodule

`default_nettype wire

FILE: rtl/core/nkdpm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nkdpm_pkg only through the common import convention.
`default_nettype none

module nkdpm_div import nkdpm_pkg::*; #(
  parameter int unsigned W  = 22,
  parameter int unsigned NW = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [W-1:0]  dividend_i,
  input  wire logic [NW-1:0] divisor_i,
  output logic               done_o,
  output logic      [W-1:0]  quot_o
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [W-1:0]     quot_q, quot_d;
  logic [NW-1:0]    rem_q, rem_d;
  logic [NW-1:0]    dvs_q, dvs_d;
  logic [NW:0]      trial;
  logic             fits;

  assign trial = {rem_q, quot_q[W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d  = CNT_W'(W);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
      quot_d = {quot_q[W-2:0], fits};
      rem_d  = fits ? NW'(trial - {1'b0, dvs_q}) : NW'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

FILE: rtl/core/nearest_k_depth_pixels_mean.sv
// Nearest-k depth pixels: keeps the k nearest pixels of a frame, emits mean column and depth.
// Flow: pixels inside a frame are taken one per cycle; after the frame-end pixel the
// table drains into the sums, the dividers run and the result loads; no pixel is taken meanwhile.
// Throughput: one pixel per cycle within a frame, as the cell row inserts each pixel as it is taken.
// Reset: control state clears, frame_width reads 640, keep_count reads 16; cells stay undefined.
`default_nettype none

module nearest_k_depth_pixels_mean import nkdpm_pkg::*; #(
  parameter int unsigned KEEP_MAX   = 64,
  parameter int unsigned WIDTH_MAX  = 2048,
  parameter int unsigned DEPTH_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Configuration write port.
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  // Pixel request channel.
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [DEPTH_PORT_W-1:0] depth_sample_i,
  input  wire logic                    frame_end_i,
  // Result request channel.
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic      [MCOL_PORT_W-1:0]  mean_column_o,
  output logic      [DEPTH_PORT_W-1:0] mean_depth_o,
  output logic      [KEPT_PORT_W-1:0]  kept_total_o
);

  // Internal widths. Depth uses only its low DEPTH_BITS bits.
  localparam int unsigned DW = (DEPTH_BITS < DEPTH_PORT_W) ? DEPTH_BITS : DEPTH_PORT_W;
  localparam int unsigned CW = $clog2(WIDTH_MAX);
  localparam int unsigned FW = $clog2(KEEP_MAX + 1);
  localparam int unsigned KW = (FW > KEPT_PORT_W) ? FW : KEPT_PORT_W;
  localparam int unsigned EW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
  localparam int unsigned SW = ((CW > DW) ? CW : DW) + FW;

  // Configuration registers.
  logic [CFG_DATA_W-1:0]  frame_width_q;
  logic [KEPT_PORT_W-1:0] keep_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= CFG_DATA_W'(WIDTH_RESET);
      keep_count_q  <= KEPT_PORT_W'(KEEP_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH: frame_width_q <= cfg_wdata_i;
        REG_KEEP_COUNT:  keep_count_q  <= cfg_wdata_i[KEPT_PORT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped configuration: zero acts as one, values above the maximum act as the maximum.
  logic [KW-1:0] keep_eff;
  logic [EW-1:0] width_eff;

  always_comb begin
    keep_eff = KW'(keep_count_q);
    if (keep_count_q == '0) begin
      keep_eff = KW'(1);
    end else if (keep_eff > KW'(KEEP_MAX)) begin
      keep_eff = KW'(KEEP_MAX);
    end
    width_eff = EW'(frame_width_q);
    if (frame_width_q == '0) begin
      width_eff = EW'(1);
    end else if (width_eff > EW'(WIDTH_MAX)) begin
      width_eff = EW'(WIDTH_MAX);
    end
  end

  // Control state.
  state_e        state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] drain_cnt_q, drain_cnt_d;
  logic [CW-1:0] col_q, col_d;
  logic [SW-1:0] sum_col_q, sum_col_d;
  logic [SW-1:0] sum_dep_q, sum_dep_d;
  logic          out_valid_q, out_valid_d;

  logic [MCOL_PORT_W-1:0]  mean_col_q;
  logic [DEPTH_PORT_W-1:0] mean_dep_q;
  logic [KEPT_PORT_W-1:0]  kept_q;
  logic                    out_load;

  logic          in_acc;
  logic [DW-1:0] new_depth;
  logic [EW-1:0] col_inc;
  logic          append;
  logic          any_gt;
  cell_ctl_t     cell_ctl;
  logic          div_start;
  logic          div_done_col, div_done_dep;
  logic [SW-1:0] quot_col, quot_dep;
  logic [FW-1:0] div_n;

  // The table is a row of cells kept sorted by depth, ties in arrival order, so the
  // entry to evict (largest depth, latest among equals) is always the last valid one.
  logic [KEEP_MAX-1:0] cell_le, cell_gt;
  logic [DW-1:0]       cell_depth [KEEP_MAX];
  logic [CW-1:0]       cell_col   [KEEP_MAX];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign new_depth  = depth_sample_i[DW-1:0];
  assign append     = (KW'(fill_q) < keep_eff);
  assign any_gt     = |cell_gt;

  // A full table takes the pixel only when it is strictly nearer than some kept entry;
  // the shift then pushes the last entry out of the valid range.
  assign cell_ctl.ins   = in_acc && (append || any_gt);
  assign cell_ctl.drain = (state_q == ST_DRAIN) && (drain_cnt_q != '0);

  for (genvar g = 0; g < KEEP_MAX; g++) begin : g_cell
    logic          left_le;
    logic [DW-1:0] left_depth, right_depth;
    logic [CW-1:0] left_col, right_col;

    if (g == 0) begin : g_first
      assign left_le    = 1'b1;
      assign left_depth = new_depth;
      assign left_col   = col_q;
    end else begin : g_mid
      assign left_le    = cell_le[g-1];
      assign left_depth = cell_depth[g-1];
      assign left_col   = cell_col[g-1];
    end

    if (g == KEEP_MAX - 1) begin : g_last
      assign right_depth = cell_depth[g];
      assign right_col   = cell_col[g];
    end else begin : g_inner
      assign right_depth = cell_depth[g+1];
      assign right_col   = cell_col[g+1];
    end

    nkdpm_cell #(
      .DW (DW),
      .CW (CW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (cell_ctl),
      .valid_i       (fill_q > FW'(g)),
      .new_depth_i   (new_depth),
      .new_col_i     (col_q),
      .left_le_i     (left_le),
      .left_depth_i  (left_depth),
      .left_col_i    (left_col),
      .right_depth_i (right_depth),
      .right_col_i   (right_col),
      .le_o          (cell_le[g]),
      .gt_o          (cell_gt[g]),
      .depth_o       (cell_depth[g]),
      .col_o         (cell_col[g])
    );
  end

  // An empty table always takes the frame-end pixel, so the kept count is at least one;
  // the guard only keeps the divider well defined.
  assign div_n = (fill_q == '0) ? FW'(1) : fill_q;

  nkdpm_div #(
    .W  (SW),
    .NW (FW)
  ) u_div_col (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_col_q),
    .divisor_i  (div_n),
    .done_o     (div_done_col),
    .quot_o     (quot_col)
  );

  nkdpm_div #(
    .W  (SW),
    .NW (FW)
  ) u_div_dep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_dep_q),
    .divisor_i  (div_n),
    .done_o     (div_done_dep),
    .quot_o     (quot_dep)
  );

  assign col_inc = EW'(col_q) + EW'(1);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    drain_cnt_d = drain_cnt_q;
    col_d       = col_q;
    sum_col_d   = sum_col_q;
    sum_dep_d   = sum_dep_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (append) begin
            fill_d = fill_q + FW'(1);
          end
          // Column wraps at the width, also when the width was lowered mid-row.
          col_d = (col_inc >= width_eff) ? '0 : CW'(col_inc);
          if (frame_end_i) begin
            col_d       = '0;
            drain_cnt_d = fill_d;
            sum_col_d   = '0;
            sum_dep_d   = '0;
            state_d     = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // Cell 0 feeds the accumulators while the row shifts toward it.
        if (drain_cnt_q != '0) begin
          sum_col_d   = sum_col_q + SW'(cell_col[0]);
          sum_dep_d   = sum_dep_q + SW'(cell_depth[0]);
          drain_cnt_d = drain_cnt_q - FW'(1);
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done_dep) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // The result register may still hold the previous frame's result.
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          fill_d      = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      drain_cnt_q <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      drain_cnt_q <= drain_cnt_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_col_q <= sum_col_d;
    sum_dep_q <= sum_dep_d;
    if (out_load) begin
      mean_col_q <= MCOL_PORT_W'(quot_col);
      mean_dep_q <= DEPTH_PORT_W'(quot_dep);
      kept_q     <= KEPT_PORT_W'(fill_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mean_column_o = mean_col_q;
  assign mean_depth_o  = mean_dep_q;
  assign kept_total_o  = kept_q;

  // An accepted pixel below the keep limit always grows the table by one.
  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && append) |=> (fill_q == $past(fill_q) + FW'(1)))
    else $error("table did not grow on append");

  // The drain never reads past the valid entries.
  a_drain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (drain_cnt_q <= fill_q))
    else $error("drain count exceeds kept count");

  // Both dividers finish together, and only while the FSM waits on them.
  a_div_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done_col || div_done_dep) |-> (div_done_col && div_done_dep && state_q == ST_DIV))
    else $error("divider completion out of step");

  // A frame always ends with at least one kept pixel.
  a_kept_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_OUT) |-> (fill_q != '0))
    else $error("empty table at frame end");

endmodule

`default_nettype wire

FILE: tb/sv/tb_nearest_k_depth_pixels_mean.sv
// Self-checking testbench for the nearest-k depth pixel mean block.
// Depends on nkdpm_pkg and nearest_k_depth_pixels_mean; it drives pixel frames and compares
// every frame result with a built-in predictor of the k nearest pixels or a typed plan row.
module tb_nearest_k_depth_pixels_mean;
  timeunit 1ns;
  timeprecision 1ps;

  import nkdpm_pkg::*;

  // Sizes of the instance under test (its defaults).
  localparam int unsigned NEAR_SLOTS = 64;
  localparam int unsigned WIDTH_CAP  = 2048;

  // Length of the run and its limits.
  localparam int unsigned RANDOM_PIXELS    = 1550;
  localparam int unsigned MIN_FRAMES       = 40;
  localparam int unsigned PIXELS_PER_PHASE = 155;
  localparam int unsigned SETTLE_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned MAX_GAP          = 40;

  // Register settings for the random phases. The extremes come first: zero and
  // oversized values for both registers, and the exact upper limits.
  localparam int unsigned PHASE_WIDTH [10] = '{1, 4095, 0, 2048, 7, 640, 2, 2049, 13, 3};
  localparam int unsigned PHASE_KEEP  [10] = '{64, 1, 127, 0, 65, 16, 2, 63, 5, 3};

  // One frame result as the block reports it.
  typedef struct packed {
    logic [MCOL_PORT_W-1:0]  column;
    logic [DEPTH_PORT_W-1:0] depth;
    logic [KEPT_PORT_W-1:0]  kept;
  } frame_mean_t;

  // A row of the directed table either sends one pixel or sets both registers.
  typedef enum logic {ROW_PIXEL, ROW_SETUP} row_kind_e;

  // For ROW_PIXEL: a is the depth and b the frame-end flag. For ROW_SETUP: a is
  // the frame width and b the keep count. Where typed is set, the result of the
  // frame closed by this pixel is the one written in the row.
  typedef struct {
    row_kind_e   kind;
    int unsigned a;
    int unsigned b;
    bit          typed;
    int unsigned col;
    int unsigned depth;
    int unsigned kept;
  } plan_row_t;

  localparam int unsigned PLAN_ROWS = 25;

  plan_row_t plan [PLAN_ROWS] = '{
    // Right after reset (width 640, keep 16): a lone pixel is its own mean.
    '{ROW_PIXEL, 100,   1, 1'b1, 0, 100,   1},
    // Zero width acts as one column and zero keep as one slot. The second zero
    // depth is not strictly nearer than the kept one, so it is dropped.
    '{ROW_SETUP, 0,     0, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 65535, 0, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 0,     0, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 0,     1, 1'b1, 0, 0,     1},
    // Oversized width and keep are clamped to the table and row limits.
    '{ROW_SETUP, 4095,  127, 1'b0, 0, 0,   0},
    '{ROW_PIXEL, 65535, 1, 1'b1, 0, 65535, 1},
    // Equal depths: the latest of the farthest entries is the one evicted,
    // and the column wraps at a width of three.
    '{ROW_SETUP, 3,     2, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 5,     0, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 5,     0, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 5,     0, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 1,     1, 1'b0, 0, 0,     0},
    // The keep count is lowered while the table already holds more entries;
    // replacement then scans all of them.
    '{ROW_SETUP, 2048,  4, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 10,    0, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 20,    0, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 30,    0, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 40,    0, 1'b0, 0, 0,     0},
    '{ROW_SETUP, 2048,  2, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 15,    1, 1'b0, 0, 0,     0},
    // The width is lowered in the middle of a row; the column still in use
    // is past the new width and has to wrap after the next pixel.
    '{ROW_SETUP, 4,     8, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 1,     0, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 2,     0, 1'b0, 0, 0,     0},
    '{ROW_SETUP, 1,     8, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 3,     0, 1'b0, 0, 0,     0},
    '{ROW_PIXEL, 4,     1, 1'b0, 0, 0,     0}
  };

  // Every input of the block holds a known value from time zero on.
  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_we_i       = 1'b0;
  logic                    cfg_idx_i      = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i    = '0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_ready_o;
  logic [DEPTH_PORT_W-1:0] depth_sample_i = '0;
  logic                    frame_end_i    = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i    = 1'b0;
  logic [MCOL_PORT_W-1:0]  mean_column_o;
  logic [DEPTH_PORT_W-1:0] mean_depth_o;
  logic [KEPT_PORT_W-1:0]  kept_total_o;

  // Idling of the two sides, in percent of cycles, set per phase.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  int unsigned mismatches   = 0;
  int unsigned frames_seen  = 0;
  int unsigned idle_cycles  = 0;

  // Predictor state: its own copy of the registers, the table of nearest
  // pixels in arrival order, and the column counter.
  logic [CFG_DATA_W-1:0]   width_shadow = CFG_DATA_W'(WIDTH_RESET);
  logic [KEPT_PORT_W-1:0]  keep_shadow  = KEPT_PORT_W'(KEEP_RESET);
  logic [DEPTH_PORT_W-1:0] near_depth  [NEAR_SLOTS];
  logic [MCOL_PORT_W-1:0]  near_column [NEAR_SLOTS];
  int unsigned             near_fill   = 0;
  int unsigned             column_now  = 0;

  // Frame results still owed by the block, oldest first.
  frame_mean_t pending_means [$];

  nearest_k_depth_pixels_mean dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .depth_sample_i (depth_sample_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mean_column_o  (mean_column_o),
    .mean_depth_o   (mean_depth_o),
    .kept_total_o   (kept_total_o)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Prints one line per mismatch and counts it; the run carries on.
  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Advances the predictor by one accepted pixel. When the pixel closes the
  // frame, the frame result is returned and the table starts over.
  task automatic absorb_pixel(input logic [DEPTH_PORT_W-1:0] d, input logic last,
                              output bit produced, output frame_mean_t mean);
    int unsigned     keep_eff;
    int unsigned     width_eff;
    int unsigned     worst;
    int unsigned     i;
    longint unsigned column_sum;
    longint unsigned depth_sum;
    longint unsigned n;
    keep_eff  = (keep_shadow == 0) ? 1 :
                (keep_shadow > NEAR_SLOTS) ? NEAR_SLOTS : keep_shadow;
    width_eff = (width_shadow == 0) ? 1 :
                (width_shadow > WIDTH_CAP) ? WIDTH_CAP : width_shadow;
    produced = 1'b0;
    mean     = '0;

    if (near_fill < keep_eff) begin
      near_depth[near_fill]  = d;
      near_column[near_fill] = MCOL_PORT_W'(column_now);
      near_fill++;
    end else if (near_fill != 0) begin
      // The candidate for eviction is the farthest entry; among equal depths
      // it is the one that arrived last. The scan covers every entry, even
      // when the keep count was lowered below the fill level.
      worst = 0;
      for (i = 1; i < near_fill; i++) begin
        if (near_depth[i] >= near_depth[worst]) begin
          worst = i;
        end
      end
      if (d < near_depth[worst]) begin
        for (i = worst; i + 1 < near_fill; i++) begin
          near_depth[i]  = near_depth[i + 1];
          near_column[i] = near_column[i + 1];
        end
        near_depth[near_fill - 1]  = d;
        near_column[near_fill - 1] = MCOL_PORT_W'(column_now);
      end
    end

    column_now++;
    if (column_now >= width_eff) begin
      column_now = 0;
    end

    if (last) begin
      column_sum = 0;
      depth_sum  = 0;
      for (i = 0; i < near_fill; i++) begin
        column_sum += near_column[i];
        depth_sum  += near_depth[i];
      end
      n           = (near_fill == 0) ? 1 : near_fill;
      mean.column = MCOL_PORT_W'(column_sum / n);
      mean.depth  = DEPTH_PORT_W'(depth_sum / n);
      mean.kept   = KEPT_PORT_W'(near_fill);
      produced    = 1'b1;
      near_fill   = 0;
      column_now  = 0;
    end
  endtask

  // Offers one pixel request after a random idle gap and waits until it is
  // taken. Valid is left high on return; the caller's next action either
  // replaces the payload or lowers valid in the same time step, once.
  task automatic send_pixel(input logic [DEPTH_PORT_W-1:0] d, input logic last,
                            input bit typed, input frame_mean_t typed_mean);
    int unsigned gap;
    bit          produced;
    frame_mean_t mean;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    depth_sample_i <= d;
    frame_end_i    <= last;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    absorb_pixel(d, last, produced, mean);
    if (produced) begin
      pending_means.insert(pending_means.size(), typed ? typed_mean : mean);
    end
  endtask

  // Lowers valid, waits for every owed result and then lets the block settle,
  // so that a register write cannot meet a pixel still being inserted.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_means.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes frame_width and then keep_count back to back. When noisy is set, the
  // unused upper bits of the keep write carry noise the block must ignore.
  task automatic write_config(input int unsigned width_val, input int unsigned keep_val,
                              input bit noisy);
    logic [CFG_DATA_W-1:0] keep_word;
    keep_word = CFG_DATA_W'(keep_val[KEPT_PORT_W-1:0]);
    if (noisy) begin
      keep_word[CFG_DATA_W-1:KEPT_PORT_W] =
        (CFG_DATA_W-KEPT_PORT_W)'($urandom_range(0, 31));
    end
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_FRAME_WIDTH;
    cfg_wdata_i <= CFG_DATA_W'(width_val);
    @(posedge clk_i);
    width_shadow = CFG_DATA_W'(width_val);
    cfg_idx_i   <= REG_KEEP_COUNT;
    cfg_wdata_i <= keep_word;
    @(posedge clk_i);
    keep_shadow = keep_word[KEPT_PORT_W-1:0];
    cfg_we_i    <= 1'b0;
  endtask

  // Frame lengths: mostly short frames so results come often, some long ones
  // that overflow even the largest table.
  function automatic int unsigned pick_frame_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 16);
    end
    if (r < 90) begin
      return $urandom_range(17, 80);
    end
    return $urandom_range(81, 150);
  endfunction

  // Depths: full range, a narrow band that produces many ties, the extremes,
  // and a middle band where eviction decisions are close.
  function automatic logic [DEPTH_PORT_W-1:0] pick_depth();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return DEPTH_PORT_W'($urandom);
    end
    if (r < 65) begin
      return DEPTH_PORT_W'($urandom_range(0, 7));
    end
    if (r < 80) begin
      return ($urandom_range(0, 1) != 0) ? {DEPTH_PORT_W{1'b1}} : {DEPTH_PORT_W{1'b0}};
    end
    return DEPTH_PORT_W'($urandom_range(1000, 1200));
  endfunction

  // Result side: sample the request at the edge, compare it with the oldest
  // expectation, then choose the ready for the next cycle.
  always @(posedge clk_i) begin
    frame_mean_t want;
    if (out_valid_o && out_ready_i) begin
      frames_seen++;
      if (pending_means.size() == 0) begin
        note_mismatch("result with nothing expected (kept_total)", kept_total_o, 0);
      end else begin
        want = pending_means.pop_front();
        if (mean_column_o !== want.column) begin
          note_mismatch("mean_column", mean_column_o, want.column);
        end
        if (mean_depth_o !== want.depth) begin
          note_mismatch("mean_depth", mean_depth_o, want.depth);
        end
        if (kept_total_o !== want.kept) begin
          note_mismatch("kept_total", kept_total_o, want.kept);
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: ends the run when no request moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned r;
    int unsigned ph;
    int unsigned taken;
    int unsigned remaining;
    int unsigned pixels_sent;
    bit          held_once;
    logic        last;
    frame_mean_t typed_mean;

    remaining   = 0;
    pixels_sent = 0;
    held_once   = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: no idling, so the table rows hit the block back to back.
    for (r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind == ROW_SETUP) begin
        wait_drained();
        write_config(plan[r].a, plan[r].b, 1'b0);
      end else begin
        typed_mean.column = MCOL_PORT_W'(plan[r].col);
        typed_mean.depth  = DEPTH_PORT_W'(plan[r].depth);
        typed_mean.kept   = KEPT_PORT_W'(plan[r].kept);
        send_pixel(DEPTH_PORT_W'(plan[r].a), plan[r].b[0], plan[r].typed, typed_mean);
      end
    end

    // Random part. Phases cut frames at arbitrary points, so new register
    // values often land in the middle of a frame or a row.
    ph = 0;
    while (pixels_sent < RANDOM_PIXELS || frames_seen < MIN_FRAMES) begin
      wait_drained();
      if (ph < 10) begin
        write_config(PHASE_WIDTH[ph], PHASE_KEEP[ph], 1'b1);
      end else begin
        write_config($urandom_range(0, 4095), $urandom_range(0, 127), 1'b1);
      end
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 61;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 61;
        end
        default: begin
          send_idle_pct = 23;
          stall_pct     = 23;
        end
      endcase

      for (taken = 0; taken < PIXELS_PER_PHASE; taken++) begin
        if (remaining == 0) begin
          remaining = pick_frame_len();
        end
        last = (remaining == 1);
        remaining--;
        send_pixel(pick_depth(), last, 1'b0, '0);
        pixels_sent++;
        // Now and then the sender holds off after a frame until its result
        // is out, so the next frame starts on an empty pipeline.
        if (last && (!held_once || $urandom_range(0, 9) == 0)) begin
          in_valid_i <= 1'b0;
          do begin
            @(posedge clk_i);
          end while (pending_means.size() != 0);
          held_once = 1'b1;
        end
      end
      ph++;
    end

    // Wind down: wait for the last results, then watch for strays.
    wait_drained();
    if (pending_means.size() != 0) begin
      note_mismatch("results never delivered", 0, pending_means.size());
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
